[rtl/core/hrd_pkg.sv]
// ----------------------------------------------------------------------------
// hrd_pkg
// shared constants and types of the hid report deframer
// ----------------------------------------------------------------------------
package hrd_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int OFFSET_W     = $clog2(REPORT_BYTES);

    localparam logic [7:0] MARK_Q = 8'h3F;
    localparam logic [7:0] MARK_H = 8'h23;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CONT = 2'd2;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] message_type;
        logic        byte_valid;
        logic        end_of_message;
        logic [1:0]  status;
    } t_result;

endpackage

[rtl/core/hrd_in_if.sv]
// ----------------------------------------------------------------------------
// hrd_in_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/core/hrd_out_if.sv]
// ----------------------------------------------------------------------------
// hrd_out_if
// result channel out of the deframer
// ----------------------------------------------------------------------------
interface hrd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] message_type;
    logic        byte_valid;
    logic        end_of_message;
    logic [1:0]  status;

    modport source (output valid, output payload_byte, output message_type,
                    output byte_valid, output end_of_message, output status,
                    input ready);
    modport sink (input valid, input payload_byte, input message_type,
                  input byte_valid, input end_of_message, input status,
                  output ready);
endinterface

[rtl/core/hrd_core.sv]
// ----------------------------------------------------------------------------
// hrd_core
// report framing state, header capture and per-beat result decision
// ----------------------------------------------------------------------------
module hrd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output logic             o_res_valid,
    output hrd_pkg::t_result o_res
);

    localparam logic [1:0] PH_FIRST   = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DRAIN   = 2'd2;

    localparam logic [hrd_pkg::OFFSET_W-1:0] OFF_LAST =
        hrd_pkg::OFFSET_W'(hrd_pkg::REPORT_BYTES - 1);

    logic [hrd_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [1:0]                   r_phase, n_phase;
    logic [15:0]                  r_type, n_type;
    logic [31:0]                  r_length, n_length;
    logic [31:0]                  r_count, n_count;
    logic [31:0]                  count_inc;
    logic [31:0]                  full_length;
    logic [1:0]                   phase_step;

    assign count_inc   = r_count + 32'd1;
    assign full_length = {r_length[31:8], i_data_byte};

    always_comb begin
        phase_step  = r_phase;
        n_type      = r_type;
        n_length    = r_length;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_FIRST: begin
                case (r_offset)
                    hrd_pkg::OFFSET_W'(0), hrd_pkg::OFFSET_W'(1),
                    hrd_pkg::OFFSET_W'(2): begin
                        if (i_data_byte != ((r_offset == '0) ? hrd_pkg::MARK_Q
                                                             : hrd_pkg::MARK_H)) begin
                            o_res_valid = 1'b1;
                            o_res.status = hrd_pkg::STATUS_BAD_HDR;
                            phase_step = PH_DRAIN;
                        end
                    end
                    hrd_pkg::OFFSET_W'(3): n_type = {i_data_byte, 8'h00};
                    hrd_pkg::OFFSET_W'(4): n_type = {r_type[15:8], i_data_byte};
                    hrd_pkg::OFFSET_W'(5): n_length = {i_data_byte, 24'h0};
                    hrd_pkg::OFFSET_W'(6): n_length = {r_length[31:24], i_data_byte, 16'h0};
                    hrd_pkg::OFFSET_W'(7): n_length = {r_length[31:16], i_data_byte, 8'h00};
                    hrd_pkg::OFFSET_W'(8): begin
                        n_length = full_length;
                        n_count  = '0;
                        if (full_length == '0) begin
                            o_res_valid = 1'b1;
                            o_res.message_type   = r_type;
                            o_res.end_of_message = 1'b1;
                            o_res.status         = hrd_pkg::STATUS_OK;
                            phase_step = PH_DRAIN;
                        end else begin
                            phase_step = PH_PAYLOAD;
                        end
                    end
                    default: ;
                endcase
            end
            PH_PAYLOAD: begin
                if (r_offset == '0) begin
                    if (i_data_byte != hrd_pkg::MARK_Q) begin
                        o_res_valid = 1'b1;
                        o_res.status = hrd_pkg::STATUS_BAD_CONT;
                        phase_step = PH_DRAIN;
                    end
                end else begin
                    n_count = count_inc;
                    o_res_valid = 1'b1;
                    o_res.payload_byte   = i_data_byte;
                    o_res.message_type   = r_type;
                    o_res.byte_valid     = 1'b1;
                    o_res.end_of_message = (count_inc == r_length);
                    o_res.status         = hrd_pkg::STATUS_OK;
                    if (count_inc == r_length) begin
                        phase_step = PH_DRAIN;
                    end
                end
            end
            default: ;
        endcase

        if (r_offset == OFF_LAST) begin
            n_offset = '0;
            n_phase  = (phase_step == PH_DRAIN) ? PH_FIRST : phase_step;
        end else begin
            n_offset = r_offset + hrd_pkg::OFFSET_W'(1);
            n_phase  = phase_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_phase  <= PH_FIRST;
            r_type   <= '0;
            r_length <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_offset <= n_offset;
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/hrd_skid.sv]
// ----------------------------------------------------------------------------
// hrd_skid
// two-entry result register with skid stage toward the output channel
// ----------------------------------------------------------------------------
module hrd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrd_pkg::t_result i_res,
    output logic             o_ready,
    hrd_out_if.source        o_out
);

    logic             r_main_v, n_main_v;
    logic             r_skid_v, n_skid_v;
    hrd_pkg::t_result r_main, n_main;
    hrd_pkg::t_result r_skid, n_skid;
    logic             pop;

    assign o_ready = !r_skid_v;
    assign pop     = r_main_v && o_out.ready;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (pop) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                n_main   = i_res;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end else if (pop) begin
            n_main_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid          = r_main_v;
    assign o_out.payload_byte   = r_main.payload_byte;
    assign o_out.message_type   = r_main.message_type;
    assign o_out.byte_valid     = r_main.byte_valid;
    assign o_out.end_of_message = r_main.end_of_message;
    assign o_out.status         = r_main.status;

endmodule

[rtl/core/hid_report_deframer_top.sv]
// ----------------------------------------------------------------------------
// hid_report_deframer_top
// a result beat is registered in the output register pair before it is offered
// throughput: one input beat per cycle, limited by the output register pair
// input ready drops only while both result entries are full
// reset: synchronous active low, framing restarts waiting for a first report
// ----------------------------------------------------------------------------
module hid_report_deframer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hrd_in_if.sink   i_in,
    hrd_out_if.source o_out
);

    logic             accept;
    logic             res_valid;
    logic             skid_ready;
    hrd_pkg::t_result res;

    assign i_in.ready = skid_ready;
    assign accept     = i_in.valid && skid_ready;

    hrd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hrd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_res   (res),
        .o_ready (skid_ready),
        .o_out   (o_out)
    );

endmodule
